// ===== design/sacl_pkg.sv =====
// Package for the set-associative LRU cache lookup.
// Constants, widths and the back-end state enum; no dependencies.
`default_nettype none
package sacl_pkg;
	localparam int NUM_SETS_DEF = 64;
	localparam int WAYS_DEF = 4;
	localparam int ADDR_W = 64;
	localparam int OFS_W = 4;
	localparam int WAY_OUT_W = 2;
	localparam logic [OFS_W-1:0] OFS_RESET = 4'd6;
	localparam int QDEPTH = 2;
	// back end: row clear after reset, idle, tag reads, update, output hold
	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_UPD, ST_OUT} back_st_t;
endpackage
`default_nettype wire

// ===== design/sacl_front.sv =====
// Front end: accepts address words, drops the line offset, splits set and tag.
// Uses sacl_pkg; feeds a two-entry queue read by sacl_back.
`default_nettype none
module sacl_front #(
	parameter int NUM_SETS = sacl_pkg::NUM_SETS_DEF,
	parameter int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [sacl_pkg::OFS_W-1:0]   ofs,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [sacl_pkg::ADDR_W-1:0]  in_addr,
	output logic                              q_valid,
	input  wire logic                         q_pop,
	output logic [SET_W-1:0]                  q_set,
	output logic [sacl_pkg::ADDR_W-1:0]       q_tag
);
	localparam int QD = sacl_pkg::QDEPTH;
	localparam bit POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
	localparam int SH = $clog2(NUM_SETS);
	localparam logic [sacl_pkg::ADDR_W-1:0] NS = sacl_pkg::ADDR_W'(NUM_SETS);
	localparam int DIG_W = 4;
	localparam int STEPS = sacl_pkg::ADDR_W / DIG_W;
	localparam int STEP_W = $clog2(STEPS + 1);
	localparam int DV_W = SET_W + DIG_W;
	// registered line number, then set/tag split
	logic                        v_s1;
	logic [sacl_pkg::ADDR_W-1:0] line_s1;
	logic [SET_W-1:0]            rem_q;
	logic [STEP_W-1:0]           step_q;
	logic                        done;
	logic [DV_W-1:0]             dv;
	logic [DIG_W-1:0]            qd;
	logic [DV_W-1:0]             dv_rem;
	logic [SET_W-1:0]            set_q [QD];
	logic [sacl_pkg::ADDR_W-1:0] tag_q [QD];
	logic                        wp_q, rp_q;
	logic [1:0]                  cnt_q;
	logic                        push;
	logic [SET_W-1:0]            set_c;
	logic [sacl_pkg::ADDR_W-1:0] tag_c;
	// power-of-two set count splits at once; otherwise radix-16 long division,
	// one quotient digit per cycle, quotient shifted into line_s1
	assign done = POW2 || (32'(step_q) == STEPS);
	assign push = v_s1 && done;
	// s1 must be free or leaving, and the queue must have room for what is in s1
	assign in_ready = (!v_s1 || push) && ((32'(cnt_q) + 32'(v_s1)) < QD);
	always_comb begin
		dv = {rem_q, line_s1[sacl_pkg::ADDR_W-1 -: DIG_W]};
		qd = '0;
		for (int k = 1; k < (1 << DIG_W); k++)
			if (32'(dv) >= k * NUM_SETS) qd = DIG_W'(k);
		dv_rem = dv - DV_W'(32'(qd) * NUM_SETS);
	end
	always_comb begin
		if (POW2) begin
			set_c = SET_W'(line_s1 & (NS - 64'd1));
			tag_c = line_s1 >> SH;
		end else begin
			set_c = rem_q;
			tag_c = line_s1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			step_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				v_s1 <= 1'b1;
				step_q <= '0;
			end else if (push) begin
				v_s1 <= 1'b0;
			end else if (v_s1) begin
				step_q <= step_q + 1'b1;
			end
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			line_s1 <= in_addr >> ofs;
			rem_q <= '0;
		end else if (v_s1 && !done) begin
			line_s1 <= {line_s1[sacl_pkg::ADDR_W-DIG_W-1:0], qd};
			rem_q <= SET_W'(dv_rem);
		end
		if (push) begin
			set_q[wp_q] <= set_c;
			tag_q[wp_q] <= tag_c;
		end
	end
	assign q_valid = cnt_q != 2'd0;
	assign q_set = set_q[rp_q];
	assign q_tag = tag_q[rp_q];
endmodule
`default_nettype wire

// ===== design/sacl_back.sv =====
// Back end: tag/valid/age lookup, LRU update, output register.
// Uses sacl_pkg; tags held in a memory, valid and age bits in one row per set.
`default_nettype none
module sacl_back #(
	parameter int NUM_SETS = sacl_pkg::NUM_SETS_DEF,
	parameter int WAYS = sacl_pkg::WAYS_DEF,
	parameter int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	output logic                             q_pop,
	input  wire logic [SET_W-1:0]            q_set,
	input  wire logic [sacl_pkg::ADDR_W-1:0] q_tag,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             out_hit,
	output logic [sacl_pkg::WAY_OUT_W-1:0]   out_way
);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NE = NUM_SETS * WAYS;
	localparam int EW = (NE > 1) ? $clog2(NE) : 1;
	localparam int AW = WAYS * WW;
	sacl_pkg::back_st_t st_q, st_d;
	logic [sacl_pkg::ADDR_W-1:0] tag_mem [NE];
	logic [sacl_pkg::ADDR_W-1:0] tag_rd_q [WAYS];
	logic [WAYS-1:0]             vld_mem [NUM_SETS];
	logic [AW-1:0]               age_mem [NUM_SETS];
	logic [WAYS-1:0]             vld_rd_q;
	logic [AW-1:0]               age_rd_q;
	logic [SET_W-1:0]            set_q;
	logic [SET_W-1:0]            clr_q;
	logic [sacl_pkg::ADDR_W-1:0] tag_q;
	logic [WW-1:0]               rd_w_q;
	logic                        hit_c;
	logic [WW-1:0]               way_c, pivot;
	logic [WAYS-1:0]             vld_nx;
	logic [AW-1:0]               age_nx, age_init;
	logic                        hit_q;
	logic [WW-1:0]               way_q;
	logic [EW-1:0]               base;
	assign base = EW'(32'(set_q) * WAYS);
	// tag row read one way per cycle (single-port memory)
	always_comb begin
		st_d = st_q;
		case (st_q)
			sacl_pkg::ST_CLEAR: if (32'(clr_q) == NUM_SETS - 1) st_d = sacl_pkg::ST_IDLE;
			sacl_pkg::ST_IDLE:  if (q_valid) st_d = sacl_pkg::ST_READ;
			sacl_pkg::ST_READ:  if (32'(rd_w_q) == WAYS - 1) st_d = sacl_pkg::ST_UPD;
			sacl_pkg::ST_UPD:   st_d = sacl_pkg::ST_OUT;
			sacl_pkg::ST_OUT: begin
				if (out_ready) st_d = q_valid ? sacl_pkg::ST_READ : sacl_pkg::ST_IDLE;
			end
			default: st_d = sacl_pkg::ST_IDLE;
		endcase
	end
	always_comb begin
		q_pop = q_valid && ((st_q == sacl_pkg::ST_IDLE) ||
			(st_q == sacl_pkg::ST_OUT && out_ready));
		out_valid = st_q == sacl_pkg::ST_OUT;
	end
	// compare tags of the set, pick victim by oldest age, build new row
	always_comb begin
		hit_c = 1'b0;
		way_c = '0;
		for (int w = WAYS - 1; w >= 0; w--)
			if (32'(age_rd_q[w*WW +: WW]) == WAYS - 1) way_c = WW'(w);
		for (int w = WAYS - 1; w >= 0; w--)
			if (vld_rd_q[w] && tag_rd_q[w] == tag_q) begin
				hit_c = 1'b1;
				way_c = WW'(w);
			end
		pivot = age_rd_q[32'(way_c) * WW +: WW];
		vld_nx = vld_rd_q | (WAYS'(1) << way_c);
		age_nx = age_rd_q;
		for (int w = 0; w < WAYS; w++)
			if (age_rd_q[w*WW +: WW] < pivot) age_nx[w*WW +: WW] = age_rd_q[w*WW +: WW] + 1'b1;
			else if (age_rd_q[w*WW +: WW] == pivot) age_nx[w*WW +: WW] = '0;
	end
	// row written during the clear: nothing valid, each age its way number
	always_comb begin
		age_init = '0;
		for (int w = 0; w < WAYS; w++)
			age_init[w*WW +: WW] = WW'(w);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sacl_pkg::ST_CLEAR;
			rd_w_q <= '0;
			clr_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == sacl_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == sacl_pkg::ST_READ)
				rd_w_q <= (32'(rd_w_q) == WAYS - 1) ? '0 : rd_w_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (q_pop) begin
			set_q <= q_set;
			tag_q <= q_tag;
		end
		if (st_q == sacl_pkg::ST_CLEAR) begin
			vld_mem[clr_q] <= '0;
			age_mem[clr_q] <= age_init;
		end
		if (st_q == sacl_pkg::ST_READ) begin
			tag_rd_q[rd_w_q] <= tag_mem[base + EW'(rd_w_q)];
			vld_rd_q <= vld_mem[set_q];
			age_rd_q <= age_mem[set_q];
		end
		if (st_q == sacl_pkg::ST_UPD) begin
			hit_q <= hit_c;
			way_q <= way_c;
			vld_mem[set_q] <= vld_nx;
			age_mem[set_q] <= age_nx;
			if (!hit_c) tag_mem[base + EW'(way_c)] <= tag_q;
		end
	end
	assign out_hit = hit_q;
	assign out_way = sacl_pkg::WAY_OUT_W'(32'(way_q) & 3);
endmodule
`default_nettype wire

// ===== design/set_assoc_cache_lru_lookup_top.sv =====
// Top level of the set-associative cache lookup with true LRU.
// Instantiates sacl_front and sacl_back; uses sacl_pkg.
//
// channel | dir | tdata
// s_axis  | in  | [63:0] address
// m_axis  | out | [0] hit, [2:1] way_used
// cfg     | in  | [3:0] line_offset_bits
//
// The back end reads the tag row one way per cycle from a single-port memory,
// then updates the set's row and registers the result for output; it takes
// the next item only once the result leaves. The front end stages the offset
// shift; a set count that is not a power of two adds radix-16 division for set
// and tag. It queues two items. After reset the back end clears one valid/age
// row per cycle, every row of the set table, before it takes the first word.
// A stalled result holds in the output register while the front keeps filling.
`default_nettype none
module set_assoc_cache_lru_lookup_top #(
	parameter int NUM_SETS = sacl_pkg::NUM_SETS_DEF,
	parameter int WAYS = sacl_pkg::WAYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // [63:0] address
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [0] hit, [2:1] way_used
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data        // [3:0] line_offset_bits
);
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	logic [sacl_pkg::OFS_W-1:0]  ofs_q;
	logic                        q_valid, q_pop, hit;
	logic [SET_W-1:0]            q_set;
	logic [sacl_pkg::ADDR_W-1:0] q_tag;
	logic [1:0]                  way;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ofs_q <= sacl_pkg::OFS_RESET;
		else if (cfg_valid) ofs_q <= cfg_data[3:0];
	end
	sacl_front #(.NUM_SETS(NUM_SETS), .SET_W(SET_W)) u_front (
		.clk, .arst_n, .ofs(ofs_q), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_addr(s_axis_tdata), .q_valid, .q_pop, .q_set, .q_tag);
	sacl_back #(.NUM_SETS(NUM_SETS), .WAYS(WAYS), .SET_W(SET_W)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_set, .q_tag, .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_hit(hit), .out_way(way));
	assign m_axis_tdata = {5'd0, way, hit};
	// a result stalled downstream must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result moved");
	// no pop from an empty queue
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop on empty");
endmodule
`default_nettype wire
